// ===== rtl/cartridge_bank_controller_macros.svh =====
// Assertion macros used by the checker file of the cartridge bank controller.
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH

// Plain clocked assertion, active during reset too.
`define CBC_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion that is switched off while reset is high.
`define CBC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/cbc_pkg.sv =====
// Types, codes and constants of the cartridge bank controller.
package cbc_pkg;

   localparam int ROM_ADDR_BITS_DEF = 23;
   localparam int RAM_ADDR_BITS_DEF = 17;
   localparam int QUEUE_DEPTH       = 2;

   localparam int PHYS_W  = 23;
   localparam int RAM_W   = 17;
   localparam int CSR_AW  = 4;

   // controller kinds
   localparam logic [2:0] MBC_NONE = 3'd0;
   localparam logic [2:0] MBC_1    = 3'd1;
   localparam logic [2:0] MBC_2    = 3'd2;
   localparam logic [2:0] MBC_3    = 3'd3;
   localparam logic [2:0] MBC_5    = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_ROM_READ  = 3'd1;
   localparam logic [2:0] KIND_RAM_READ  = 3'd2;
   localparam logic [2:0] KIND_RAM_WRITE = 3'd3;
   localparam logic [2:0] KIND_REG_WRITE = 3'd4;
   localparam logic [2:0] KIND_RAM_OFF   = 3'd5;

   // access classes decided by the front end
   localparam logic [2:0] CLS_NONE   = 3'd0;
   localparam logic [2:0] CLS_ROM_LO = 3'd1;
   localparam logic [2:0] CLS_ROM_HI = 3'd2;
   localparam logic [2:0] CLS_RAM    = 3'd3;
   localparam logic [2:0] CLS_REG    = 3'd4;

   // register window zones, address bits 14:13
   localparam logic [1:0] ZONE_RAM_EN   = 2'd0;
   localparam logic [1:0] ZONE_ROM_BANK = 2'd1;
   localparam logic [1:0] ZONE_RAM_BANK = 2'd2;
   localparam logic [1:0] ZONE_MODE     = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_MBC_KIND  = 2'd0;
   localparam logic [1:0] REG_ROM_SIZE  = 2'd1;
   localparam logic [1:0] REG_RAM_COUNT = 2'd2;
   localparam logic [1:0] REG_MULTICART = 2'd3;

   localparam logic [3:0] RAM_EN_KEY   = 4'hA;
   localparam logic [3:0] ROM_CODE_MAX = 4'd8;
   localparam logic [3:0] ROM_CODE_64  = 4'd5;
   localparam logic [8:0] MC_HI_BITS   = 9'h030;
   localparam logic [8:0] STD_HI_BITS  = 9'h060;
   localparam logic [8:0] MBC2_RAM_TOP = 9'h1FF;

   typedef struct packed {
      logic [2:0] mbc_kind;
      logic [3:0] rom_size_code;
      logic [4:0] ram_bank_count;
      logic       multicart;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  cls;
      logic        req_type;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
   } item_type;

   typedef struct packed {
      logic [2:0]        access_kind;
      logic [PHYS_W-1:0] phys_addr;
      logic [7:0]        ram_wdata;
      logic              high_nibble_set;
   } rsp_type;

endpackage

// ===== rtl/cbc_front.sv =====
// Front end: accepts bus accesses and sorts them into access classes.
module cbc_front
   import cbc_pkg::*;
(
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_type,
   input  logic [15:0] bus_address,
   input  logic [7:0]  write_data,
   input  logic        q_full,
   output logic        q_push,
   output item_type    q_item
);

   logic [2:0] cls;

   always_comb begin
      if (!bus_address[15]) begin
         if (req_type) begin
            cls = CLS_REG;
         end else if (bus_address[14]) begin
            cls = CLS_ROM_HI;
         end else begin
            cls = CLS_ROM_LO;
         end
      end else if (bus_address[15:13] == 3'b101) begin
         cls = CLS_RAM;
      end else begin
         cls = CLS_NONE;
      end
   end

   assign req_tready         = !q_full;
   assign q_push             = req_tvalid && !q_full;
   assign q_item.cls         = cls;
   assign q_item.req_type    = req_type;
   assign q_item.bus_address = bus_address;
   assign q_item.write_data  = write_data;

endmodule

// ===== rtl/cbc_queue.sv =====
// Short show-ahead queue between the front end and the back end.
module cbc_queue
   import cbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/cbc_back.sv =====
// Back end: bank registers, address translation and the result register.
module cbc_back
   import cbc_pkg::*;
#(
   parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
   parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     head_valid,
   input  item_type head_item,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   logic [8:0] rom_bank_ff, rom_bank_in;
   logic [3:0] ram_bank_ff, ram_bank_in;
   logic       ram_en_ff, ram_en_in;
   logic       adv_ff, adv_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic [3:0]        code;
   logic [8:0]        bank_mask;
   logic [3:0]        ram_mask;
   logic              is_mbc1, is_mbc2;
   logic [15:0]       addr;
   logic [7:0]        v;
   logic [1:0]        zone;
   logic [4:0]        low5;
   logic [3:0]        low4;
   logic [1:0]        hi2;
   logic [8:0]        lo_bank;
   logic [22:0]       rom_full;
   logic [RAM_W-1:0]  ram_full;
   logic              ram_ok;

   assign pop       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      code      = (cfg.rom_size_code > ROM_CODE_MAX) ? ROM_CODE_MAX : cfg.rom_size_code;
      bank_mask = 9'((10'd2 << code) - 10'd1);
      if (cfg.ram_bank_count == 5'd0) begin
         ram_mask = 4'd0;
      end else if (cfg.ram_bank_count >= 5'd16) begin
         ram_mask = 4'hF;
      end else begin
         ram_mask = 4'(cfg.ram_bank_count - 5'd1);
      end
      is_mbc1 = (cfg.mbc_kind == MBC_1);
      is_mbc2 = (cfg.mbc_kind == MBC_2);
      addr    = head_item.bus_address;
      v       = head_item.write_data;
      zone    = addr[14:13];
   end

   // bank register updates
   always_comb begin
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      ram_en_in   = ram_en_ff;
      adv_in      = adv_ff;
      low5        = '0;
      low4        = '0;
      hi2         = '0;
      if (pop && head_item.cls == CLS_REG) begin
         case (cfg.mbc_kind)
            MBC_1: begin
               case (zone)
                  ZONE_RAM_EN: ram_en_in = (v[3:0] == RAM_EN_KEY);
                  ZONE_ROM_BANK: begin
                     if (cfg.multicart) begin
                        low4        = (v[4:0] == 5'd0) ? 4'd1 : v[3:0];
                        rom_bank_in = {rom_bank_ff[8:4], low4};
                     end else begin
                        low5        = ((v[4:0] == 5'd0) ? 5'd1 : v[4:0]) & bank_mask[4:0];
                        rom_bank_in = {rom_bank_ff[8:5], low5};
                     end
                  end
                  ZONE_RAM_BANK: begin
                     if (cfg.multicart) begin
                        rom_bank_in = {rom_bank_ff[8:6], v[1:0], rom_bank_ff[3:0]};
                     end else begin
                        ram_bank_in = {2'b00, v[1:0]} & ram_mask;
                        if (code == ROM_CODE_64) begin
                           hi2 = {1'b0, v[0]};
                        end else if (code < ROM_CODE_64) begin
                           hi2 = 2'b00;
                        end else begin
                           hi2 = v[1:0];
                        end
                        rom_bank_in = {rom_bank_ff[8:7], hi2, rom_bank_ff[4:0]};
                     end
                  end
                  default: adv_in = v[0];
               endcase
            end
            MBC_2: begin
               if (!addr[14]) begin
                  if (addr[8]) begin
                     rom_bank_in = ((v[3:0] == 4'd0) ? 9'd1 : {5'd0, v[3:0]}) & bank_mask;
                  end else begin
                     ram_en_in = (v[3:0] == RAM_EN_KEY);
                  end
               end
            end
            MBC_3: begin
               case (zone)
                  ZONE_RAM_EN:   ram_en_in = (v == {4'd0, RAM_EN_KEY});
                  ZONE_ROM_BANK: rom_bank_in = (v == 8'd0) ? 9'd1 : {1'b0, v};
                  ZONE_RAM_BANK: ram_bank_in = v[3:0] & ram_mask;
                  default: ;
               endcase
            end
            MBC_5: begin
               case (zone)
                  ZONE_RAM_EN: ram_en_in = (v == {4'd0, RAM_EN_KEY});
                  ZONE_ROM_BANK: begin
                     if (!addr[12]) begin
                        rom_bank_in = (rom_bank_ff & ~{1'b0, bank_mask[7:0]})
                                    | {1'b0, v & bank_mask[7:0]};
                     end else if (code == ROM_CODE_MAX) begin
                        rom_bank_in = {v[0], rom_bank_ff[7:0]};
                     end
                  end
                  ZONE_RAM_BANK: ram_bank_in = v[3:0] & ram_mask;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // translation
   always_comb begin
      lo_bank = '0;
      if (is_mbc1 && adv_ff) begin
         if (cfg.multicart) begin
            lo_bank = rom_bank_ff & MC_HI_BITS;
         end else if (code >= ROM_CODE_64) begin
            lo_bank = rom_bank_ff & STD_HI_BITS;
         end
      end
      rom_full = (head_item.cls == CLS_ROM_LO) ? {lo_bank, addr[13:0]}
                                                : {rom_bank_ff, addr[13:0]};
      rom_full = rom_full & {bank_mask, 14'h3FFF};

      if (is_mbc1 && !adv_ff) begin
         ram_full = {4'd0, addr[12:0]};
      end else if (is_mbc2) begin
         ram_full = {8'd0, addr[8:0] & MBC2_RAM_TOP};
      end else begin
         ram_full = {ram_bank_ff & ram_mask, addr[12:0]};
      end
      ram_ok = ram_en_ff && (is_mbc2 || cfg.ram_bank_count != 5'd0);

      rsp_in = '0;
      case (head_item.cls)
         CLS_REG: rsp_in.access_kind = KIND_REG_WRITE;
         CLS_ROM_LO, CLS_ROM_HI: begin
            rsp_in.access_kind = KIND_ROM_READ;
            rsp_in.phys_addr   = PHYS_W'(rom_full[ROM_ADDR_BITS-1:0]);
         end
         CLS_RAM: begin
            if (ram_ok) begin
               rsp_in.phys_addr = PHYS_W'(ram_full[RAM_ADDR_BITS-1:0]);
               if (head_item.req_type) begin
                  rsp_in.access_kind = KIND_RAM_WRITE;
                  rsp_in.ram_wdata   = is_mbc2 ? {4'd0, v[3:0]} : v;
               end else begin
                  rsp_in.access_kind     = KIND_RAM_READ;
                  rsp_in.high_nibble_set = is_mbc2;
               end
            end else begin
               rsp_in.access_kind = KIND_RAM_OFF;
            end
         end
         default: rsp_in.access_kind = KIND_NONE;
      endcase

      rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff  <= 9'd1;
         ram_bank_ff  <= '0;
         ram_en_ff    <= 1'b0;
         adv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rom_bank_ff  <= rom_bank_in;
         ram_bank_ff  <= ram_bank_in;
         ram_en_ff    <= ram_en_in;
         adv_ff       <= adv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/cartridge_bank_controller.sv =====
// Cartridge bank controller: translates CPU cartridge accesses and tracks bank registers.
//
// Input stream (req_*): one CPU bus access per item, read or write, with the
// 16-bit address and the data byte. Result stream (rsp_*): exactly one item
// per access, in order: access kind, physical ROM or RAM byte address, RAM
// write byte and the MBC2 upper-nibble flag.
// The front end decodes the address range and pushes into a two-entry queue;
// the back end applies register writes and translates addresses in one pass
// and holds the result in an output register.
// An accepted item is registered in the queue and then in the output register
// before rsp_tvalid rises. One item per cycle is sustained while rsp_tready
// stays high.
// A register write takes effect for the very next item.
// When rsp_tready is low the result holds, the two queue entries fill and
// req_tready drops; nothing is lost.
// Reset clears the queue and output, sets ROM bank 1, RAM bank 0, RAM off and
// simple banking mode; configuration registers return to 0.
// Configuration (csr_*) is an APB write port with registers at 4-byte steps,
// to be written only while no item is in flight.
module cartridge_bank_controller
   import cbc_pkg::*;
#(
   parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
   parameter int RAM_ADDR_BITS = RAM_ADDR_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // bus_address[15:0], write_data[23:16]
   input  logic [0:0]        req_tuser,   // req_type[0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // phys_addr[22:0], ram_wdata[30:23], zero[31]
   output logic [3:0]        rsp_tuser,   // access_kind[2:0], high_nibble_set[3]
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type  cfg_ff, cfg_in;
   logic     cfg_we;
   logic     q_full, q_push, q_pop, q_head_valid;
   item_type q_item, q_head;
   rsp_type  rsp;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_we) begin
         case (csr_paddr[3:2])
            REG_MBC_KIND:  cfg_in.mbc_kind       = csr_pwdata[2:0];
            REG_ROM_SIZE:  cfg_in.rom_size_code  = csr_pwdata[3:0];
            REG_RAM_COUNT: cfg_in.ram_bank_count = csr_pwdata[4:0];
            REG_MULTICART: cfg_in.multicart      = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_MBC_KIND:  csr_prdata = {29'd0, cfg_ff.mbc_kind};
         REG_ROM_SIZE:  csr_prdata = {28'd0, cfg_ff.rom_size_code};
         REG_RAM_COUNT: csr_prdata = {27'd0, cfg_ff.ram_bank_count};
         REG_MULTICART: csr_prdata = {31'd0, cfg_ff.multicart};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbc_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_type    (req_tuser[0]),
      .bus_address (req_tdata[15:0]),
      .write_data  (req_tdata[23:16]),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_item)
   );

   cbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head)
   );

   cbc_back #(
      .ROM_ADDR_BITS (ROM_ADDR_BITS),
      .RAM_ADDR_BITS (RAM_ADDR_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (q_head_valid),
      .head_item  (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.ram_wdata, rsp.phys_addr};
   assign rsp_tuser = {rsp.high_nibble_set, rsp.access_kind};

endmodule

// ===== rtl/cbc_checker.sv =====
// Port-level checker for the cartridge bank controller, bound to the top level.
`include "cartridge_bank_controller_macros.svh"

module cbc_checker
   import cbc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   `CBC_ASSERT(a_idle_after_reset, clock, reset |=> !rsp_tvalid, "result valid after reset")

   `CBC_ASSERT_RST(a_hold_on_stall, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled result changed")

   `CBC_ASSERT_RST(a_kind_range, clock, reset,
      rsp_tvalid |-> rsp_tuser[2:0] <= KIND_RAM_OFF, "access kind out of range")

   `CBC_ASSERT_RST(a_no_addr_on_other, clock, reset,
      rsp_tvalid && (rsp_tuser[2:0] == KIND_NONE || rsp_tuser[2:0] == KIND_REG_WRITE ||
                     rsp_tuser[2:0] == KIND_RAM_OFF) |-> rsp_tdata == 32'd0,
      "address or data on a kind that carries none")

   `CBC_ASSERT_RST(a_nibble_on_read, clock, reset,
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == KIND_RAM_READ && rsp_tdata[30:23] == 8'd0,
      "nibble flag outside a RAM read")

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== test/cartridge_bank_controller_tb.sv =====
// Self-checking testbench for the cartridge bank controller: stream stimulus and bank prediction.
`timescale 1ns / 1ps

module cartridge_bank_controller_tb
   import cbc_pkg::*;
();

   localparam logic       ACC_READ     = 1'b0;
   localparam logic       ACC_WRITE    = 1'b1;
   localparam logic [2:0] MBC_UNKNOWN  = 3'd7;
   localparam int unsigned BANK16K     = 32'h4000;
   localparam int unsigned BANK8K      = 32'h2000;
   localparam int unsigned RAM_LIMIT   = 32'h1FFFF;
   localparam int         STALL_LIMIT  = 2000;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         PHASE_ITEMS  = 165;

   typedef struct packed {
      logic        wr;
      logic [15:0] addr;
      logic [7:0]  data;
   } cpu_access_type;

   logic              clock;
   logic              reset        = 1'b1;
   logic              req_tvalid   = 1'b0;
   logic              req_tready;
   logic [23:0]       req_tdata    = '0;   // bus_address[15:0], write_data[23:16]
   logic [0:0]        req_tuser    = '0;   // req_type[0]
   logic              rsp_tvalid;
   logic              rsp_tready   = 1'b0;
   logic [31:0]       rsp_tdata;           // phys_addr[22:0], ram_wdata[30:23], zero[31]
   logic [3:0]        rsp_tuser;           // access_kind[2:0], high_nibble_set[3]
   logic              csr_psel     = 1'b0;
   logic              csr_penable  = 1'b0;
   logic              csr_pwrite   = 1'b0;
   logic [CSR_AW-1:0] csr_paddr    = '0;
   logic [31:0]       csr_pwdata   = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   cartridge_bank_controller dut (.*);

   // shadow configuration and bank state
   logic [2:0]  cfg_kind      = MBC_NONE;
   logic [3:0]  cfg_rom_code  = '0;
   logic [4:0]  cfg_ram_count = '0;
   logic        cfg_multi     = 1'b0;
   int unsigned rom_bank_sel  = 1;
   int unsigned ram_bank_sel  = 0;
   logic        ram_on        = 1'b0;
   logic        adv_mode      = 1'b0;

   cpu_access_type access_queue[$];
   rsp_type        expected_translations[$];
   cpu_access_type offered;
   int          idle_pct       = 0;
   int          stall_pct      = 0;
   logic        hold_want      = 1'b0;
   logic        hold_done;
   int          hold_left;
   int          mismatch_count = 0;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned rom_bank_total();
      logic [3:0] code;
      code = (cfg_rom_code > ROM_CODE_MAX) ? ROM_CODE_MAX : cfg_rom_code;
      return 32'd2 << code;
   endfunction

   function automatic int unsigned ram_bank_mask();
      logic [4:0] top;
      top = cfg_ram_count - 5'd1;
      if (cfg_ram_count == 0) return 0;
      if (cfg_ram_count >= 16) return 32'hF;
      return 32'(top[3:0]);
   endfunction

   function automatic logic [22:0] rom_cut(int unsigned byte_addr);
      int unsigned lim;
      logic [22:0] cut;
      lim = rom_bank_total() * BANK16K - 1;
      cut = 23'(byte_addr & lim);
      return cut;
   endfunction

   function automatic void update_banks(logic [15:0] a, int unsigned v);
      int unsigned nb;
      int unsigned bm;
      nb = rom_bank_total();
      bm = nb - 1;
      case (cfg_kind)
         MBC_1: begin
            if (a < 16'h2000) begin
               ram_on = ((v & 32'hF) == RAM_EN_KEY);
            end else if (a < 16'h4000) begin
               if (cfg_multi) begin
                  if ((v & 32'h1F) == 0) v = v | 1;
                  v = v & 32'hF;
                  rom_bank_sel = (rom_bank_sel & ~32'hF) | v;
               end else begin
                  v = v & 32'h1F;
                  if (v == 0) v = 1;
                  v = v & bm;
                  rom_bank_sel = (rom_bank_sel & ~32'h1F) | v;
               end
            end else if (a < 16'h6000) begin
               v = v & 32'h3;
               if (cfg_multi) begin
                  rom_bank_sel = (rom_bank_sel & ~32'h30) | (v << 4);
               end else begin
                  ram_bank_sel = v & ram_bank_mask();
                  if (nb == 64) v = v & 32'h1;
                  else if (nb < 128) v = 0;
                  rom_bank_sel = (rom_bank_sel & ~32'h60) | (v << 5);
               end
            end else begin
               adv_mode = v[0];
            end
         end
         MBC_2: begin
            if (a < 16'h4000) begin
               v = v & 32'hF;
               // address bit 8 picks ROM bank versus RAM enable
               if (a[8]) rom_bank_sel = ((v == 0) ? 1 : v) & bm;
               else ram_on = (v == RAM_EN_KEY);
            end
         end
         MBC_3: begin
            if (a < 16'h2000) ram_on = (v == RAM_EN_KEY);
            else if (a < 16'h4000) rom_bank_sel = (v == 0) ? 1 : v;
            else if (a < 16'h6000) ram_bank_sel = v & ram_bank_mask();
         end
         MBC_5: begin
            if (a < 16'h2000) begin
               ram_on = (v == RAM_EN_KEY);
            end else if (a < 16'h3000) begin
               rom_bank_sel = (rom_bank_sel & ~(bm & 32'hFF)) | (v & bm & 32'hFF);
            end else if (a < 16'h4000) begin
               if (nb > 256) rom_bank_sel = (rom_bank_sel & 32'hFEFF) | ((v & 32'h1) << 8);
            end else if (a < 16'h6000) begin
               ram_bank_sel = v & ram_bank_mask() & 32'hF;
            end
         end
         default: ;
      endcase
      rom_bank_sel = rom_bank_sel & 32'h1FF;
      ram_bank_sel = ram_bank_sel & 32'hF;
   endfunction

   function automatic rsp_type translate_access(cpu_access_type acc);
      rsp_type     r;
      int unsigned off;
      int unsigned phys;
      int unsigned wd;
      logic        mbc1;
      logic        mbc2;
      r    = '0;
      mbc1 = (cfg_kind == MBC_1);
      mbc2 = (cfg_kind == MBC_2);
      r.access_kind = KIND_NONE;
      if (acc.addr < 16'h8000) begin
         if (acc.wr == ACC_WRITE) begin
            update_banks(acc.addr, 32'(acc.data));
            r.access_kind = KIND_REG_WRITE;
         end else if (acc.addr < 16'h4000) begin
            off = 0;
            if (mbc1 && cfg_multi && adv_mode)
               off = (rom_bank_sel & 32'h30) * BANK16K;
            else if (mbc1 && rom_bank_total() > 32 && adv_mode)
               off = (rom_bank_sel & 32'h60) * BANK16K;
            r.access_kind = KIND_ROM_READ;
            r.phys_addr   = rom_cut(acc.addr + off);
         end else begin
            r.access_kind = KIND_ROM_READ;
            r.phys_addr   = rom_cut(acc.addr - BANK16K + rom_bank_sel * BANK16K);
         end
      end else if (acc.addr >= 16'hA000 && acc.addr < 16'hC000) begin
         off = acc.addr - 16'hA000;
         if (ram_on && (mbc2 || cfg_ram_count != 0)) begin
            if (mbc1 && !adv_mode) begin
               phys = off;
               wd   = 32'(acc.data);
            end else if (mbc2) begin
               // built-in 512 x 4 bit RAM
               phys = off & 32'h1FF;
               wd   = 32'(acc.data & 8'h0F);
               r.high_nibble_set = (acc.wr == ACC_READ);
            end else begin
               phys = off + (ram_bank_sel & ram_bank_mask()) * BANK8K;
               wd   = 32'(acc.data);
            end
            r.phys_addr   = 23'(phys & RAM_LIMIT);
            r.access_kind = (acc.wr == ACC_WRITE) ? KIND_RAM_WRITE : KIND_RAM_READ;
            r.ram_wdata   = (acc.wr == ACC_WRITE) ? wd[7:0] : 8'h00;
         end else begin
            r.access_kind = KIND_RAM_OFF;
         end
      end
      return r;
   endfunction

   // driver: predict on acceptance, then offer the next item
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_translations.push_back(translate_access(offered));
         if (!req_tvalid || req_tready) begin
            if (access_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               offered = access_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {offered.data, offered.addr};
               req_tuser  <= offered.wr;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side ready, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_want && !hold_done) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_translations.size() == 0) begin
            $error("result item with no access waiting");
            mismatch_count++;
         end else begin
            want = expected_translations.pop_front();
            if (rsp_tuser[2:0] != want.access_kind) begin
               $error("access_kind expected %0d got %0d", want.access_kind, rsp_tuser[2:0]);
               mismatch_count++;
            end
            if (rsp_tdata[22:0] != want.phys_addr) begin
               $error("phys_addr expected 0x%0h got 0x%0h", want.phys_addr, rsp_tdata[22:0]);
               mismatch_count++;
            end
            if (rsp_tdata[30:23] != want.ram_wdata) begin
               $error("ram_wdata expected 0x%0h got 0x%0h", want.ram_wdata, rsp_tdata[30:23]);
               mismatch_count++;
            end
            if (rsp_tuser[3] != want.high_nibble_set) begin
               $error("high_nibble_set expected %0d got %0d", want.high_nibble_set,
                      rsp_tuser[3]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[cartridge_bank_controller] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MBC_KIND:  cfg_kind      = val[2:0];
         REG_ROM_SIZE:  cfg_rom_code  = val[3:0];
         REG_RAM_COUNT: cfg_ram_count = val[4:0];
         REG_MULTICART: cfg_multi     = val[0];
         default: ;
      endcase
   endtask

   task automatic apply_setup(input logic [2:0] kind, input logic [3:0] code,
                              input logic [4:0] count, input logic multi);
      csr_write(REG_MBC_KIND, {29'd0, kind});
      csr_write(REG_ROM_SIZE, {28'd0, code});
      csr_write(REG_RAM_COUNT, {27'd0, count});
      csr_write(REG_MULTICART, {31'd0, multi});
   endtask

   task automatic queue_access(input logic wr, input logic [15:0] addr, input logic [7:0] data);
      access_queue.push_back('{wr: wr, addr: addr, data: data});
   endtask

   task automatic drain();
      while (access_queue.size() != 0 || expected_translations.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // mostly well-formed accesses: register writes biased to enable keys and small banks
   function automatic cpu_access_type random_access();
      cpu_access_type acc;
      int unsigned    sel;
      sel      = $urandom_range(99);
      acc.data = 8'($urandom_range(255));
      acc.wr   = 1'($urandom_range(1));
      acc.addr = 16'($urandom_range(16'hFFFF));
      if (sel < 30) begin
         acc.wr   = ACC_READ;
         acc.addr = 16'($urandom_range(16'h7FFF));
      end else if (sel < 62) begin
         acc.wr   = ACC_WRITE;
         acc.addr = 16'($urandom_range(16'h7FFF));
         case ($urandom_range(3))
            0: acc.data = {4'h0, RAM_EN_KEY};
            1: acc.data[3:0] = RAM_EN_KEY;
            2: acc.data = 8'($urandom_range(31));
            default: ;
         endcase
      end else if (sel < 92) begin
         acc.addr = 16'h A000 + 16'($urandom_range(16'h1FFF));
      end
      return acc;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // MBC1 walk-through with 128 banks and four RAM banks
      apply_setup(MBC_1, 4'd6, 5'd4, 1'b0);
      queue_access(ACC_READ,  16'h0000, 8'h00);
      queue_access(ACC_READ,  16'h7FFF, 8'hFF);
      queue_access(ACC_READ,  16'h4000, 8'h00);
      queue_access(ACC_READ,  16'hA000, 8'h00);  // RAM still off
      queue_access(ACC_WRITE, 16'h0000, 8'h0A);
      queue_access(ACC_WRITE, 16'h2000, 8'h00);  // bank 0 maps to 1
      queue_access(ACC_READ,  16'h4000, 8'h00);
      queue_access(ACC_WRITE, 16'h4000, 8'h03);
      queue_access(ACC_WRITE, 16'h3FFF, 8'hFF);  // low bits only, upper kept
      queue_access(ACC_READ,  16'h7FFF, 8'h00);
      queue_access(ACC_WRITE, 16'h6000, 8'h01);
      queue_access(ACC_READ,  16'h0000, 8'h00);
      queue_access(ACC_READ,  16'hA000, 8'h00);
      queue_access(ACC_WRITE, 16'hBFFF, 8'hFF);
      queue_access(ACC_WRITE, 16'h7FFF, 8'h00);
      queue_access(ACC_READ,  16'hA123, 8'h00);
      queue_access(ACC_READ,  16'h8000, 8'h00);
      queue_access(ACC_WRITE, 16'h9FFF, 8'hFF);
      queue_access(ACC_READ,  16'hC000, 8'h00);
      queue_access(ACC_WRITE, 16'hFFFF, 8'hFF);
      queue_access(ACC_WRITE, 16'h1FFF, 8'hF0);  // disable
      queue_access(ACC_WRITE, 16'hA000, 8'h55);
      queue_access(ACC_READ,  16'hBFFF, 8'h00);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0:  apply_setup(MBC_5, 4'd8, 5'd16, 1'b0);
            1:  apply_setup(MBC_2, 4'd0, 5'd0, 1'b1);
            2:  apply_setup(MBC_3, 4'd7, 5'd8, 1'b0);
            3:  apply_setup(MBC_1, 4'd5, 5'd3, 1'b1);
            4:  apply_setup(MBC_1, 4'd8, 5'd31, 1'b0);
            5:  apply_setup(MBC_UNKNOWN, 4'd15, 5'd31, 1'b1);
            6:  apply_setup(MBC_NONE, 4'd0, 5'd0, 1'b0);
            7:  apply_setup(MBC_1, 4'd5, 5'd1, 1'b0);
            8:  apply_setup(MBC_5, 4'd15, 5'd5, 1'b1);
            default:
               apply_setup(3'($urandom_range(7)), 4'($urandom_range(15)),
                           5'($urandom_range(31)), 1'($urandom_range(1)));
         endcase
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++)
            access_queue.push_back(random_access());
         // back-pressure: result side blocked while the sender keeps offering
         if (ph == 4) hold_want = 1'b1;
         drain();
      end

      if (mismatch_count == 0 && expected_translations.size() == 0)
         $display("[cartridge_bank_controller] OK");
      else
         $display("[cartridge_bank_controller] ERROR");
      $finish;
   end

endmodule
